// File: hw/rtl/opte_pkg.sv
// Shared types, sizes and codes of the OFDM pilot-tap equalizer.
package opte_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int FRAC_BITS = 14;
    localparam int CAR_W     = 10;
    localparam int FFT_LEN   = 2 ** CAR_W;
    localparam int TAP_W     = 2 * SAMPLE_W;

    // Quotient width before rounding: one guard bit for rounding, one for the cap.
    localparam int QUO_W = SAMPLE_W + 2;
    // Low dividend bits that the divider steps bring in before the zero bits.
    localparam int LOW_W = QUO_W - FRAC_BITS - 1;
    localparam int MAG_W = 2 * SAMPLE_W;
    localparam int DEN_W = 2 * SAMPLE_W;
    localparam int REM_W = DEN_W + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CAM_DEPTH = 32;
    localparam int CAM_PTR_W = $clog2(CAM_DEPTH);
    localparam int CAM_CNT_W = $clog2(CAM_DEPTH + 1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EQ   = 1'b1;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_DATA,
        KIND_PILOT
    } kind_t;

    // Word handed from the front to the back: dividend a, divisor b, passed value p.
    typedef struct packed {
        kind_t                      kind;
        logic [CAR_W-1:0]           carrier;
        logic                       frame_end;
        logic signed [SAMPLE_W-1:0] a_re;
        logic signed [SAMPLE_W-1:0] a_im;
        logic signed [SAMPLE_W-1:0] b_re;
        logic signed [SAMPLE_W-1:0] b_im;
        logic [SAMPLE_W-1:0]        p_re;
        logic [SAMPLE_W-1:0]        p_im;
    } work_t;

    typedef struct packed {
        logic             en;
        logic [CAR_W-1:0] carrier;
        logic [TAP_W-1:0] tap;
    } tap_wr_t;

endpackage

// File: hw/rtl/opte_in_if.sv
// Input channel of the equalizer: one subcarrier word per handshake.
interface opte_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  op;
    logic [opte_pkg::CAR_W-1:0]            carrier;
    logic signed [opte_pkg::SAMPLE_W-1:0]  sample_re;
    logic signed [opte_pkg::SAMPLE_W-1:0]  sample_im;
    logic                                  occupied;
    logic                                  is_pilot;
    logic signed [opte_pkg::SAMPLE_W-1:0]  pilot_re;
    logic signed [opte_pkg::SAMPLE_W-1:0]  pilot_im;
    logic                                  frame_end;

    modport source (
        output valid, op, carrier, sample_re, sample_im, occupied, is_pilot,
               pilot_re, pilot_im, frame_end,
        input  ready
    );
    modport sink (
        input  valid, op, carrier, sample_re, sample_im, occupied, is_pilot,
               pilot_re, pilot_im, frame_end,
        output ready
    );
endinterface

// File: hw/rtl/opte_out_if.sv
// Output channel of the equalizer: one equalized word per handshake.
interface opte_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [opte_pkg::CAR_W-1:0]            carrier_out;
    logic signed [opte_pkg::SAMPLE_W-1:0]  out_re;
    logic signed [opte_pkg::SAMPLE_W-1:0]  out_im;
    logic                                  div_error;
    logic                                  frame_end_out;

    modport source (
        output valid, carrier_out, out_re, out_im, div_error, frame_end_out,
        input  ready
    );
    modport sink (
        input  valid, carrier_out, out_re, out_im, div_error, frame_end_out,
        output ready
    );
endinterface

// File: hw/rtl/opte_queue.sv
// Short word queue between the front and the back of the equalizer.
module opte_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  opte_pkg::work_t               push_data,
    input  logic                          pop,
    output opte_pkg::work_t               head,
    output logic [opte_pkg::QCNT_W-1:0]   count
);

    opte_pkg::work_t                 mem_reg [opte_pkg::QUEUE_DEPTH];
    logic [opte_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [opte_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [opte_pkg::QCNT_W-1:0]     count_reg;
    logic [opte_pkg::QCNT_W-1:0]     count_next;

    always_comb
    begin
        count_next = count_reg + opte_pkg::QCNT_W'(push) - opte_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

// File: hw/rtl/opte_front.sv
// Front of the equalizer: accepts words, holds the tap memory and classifies carriers.
module opte_front (
    input  logic                          clk,
    input  logic                          rst_n,
    opte_in_if.sink                       samples,
    input  opte_pkg::tap_wr_t             wr,
    input  logic [opte_pkg::QCNT_W-1:0]   q_count,
    output logic                          push,
    output opte_pkg::work_t               push_data
);

    typedef struct packed {
        opte_pkg::kind_t                      kind;
        logic [opte_pkg::CAR_W-1:0]           carrier;
        logic                                 frame_end;
        logic signed [opte_pkg::SAMPLE_W-1:0] s_re;
        logic signed [opte_pkg::SAMPLE_W-1:0] s_im;
        logic signed [opte_pkg::SAMPLE_W-1:0] pl_re;
        logic signed [opte_pkg::SAMPLE_W-1:0] pl_im;
    } s1_item_t;

    logic [opte_pkg::TAP_W-1:0]      tap_mem [opte_pkg::FFT_LEN];
    logic [opte_pkg::TAP_W-1:0]      rd_reg;
    logic                            s1_valid_reg;
    s1_item_t                        s1_item_reg;
    s1_item_t                        s1_item_next;

    logic [opte_pkg::CAR_W-1:0]      cam_car_reg [opte_pkg::CAM_DEPTH];
    logic [opte_pkg::CAM_DEPTH-1:0]  cam_vld_reg;
    logic [opte_pkg::CAM_DEPTH-1:0]  cam_vld_next;
    logic [opte_pkg::CAM_PTR_W-1:0]  cam_wr_reg;
    logic [opte_pkg::CAM_PTR_W-1:0]  cam_rd_reg;
    logic [opte_pkg::CAM_CNT_W-1:0]  cam_cnt_reg;
    logic [opte_pkg::CAM_CNT_W-1:0]  cam_cnt_next;

    logic is_load;
    logic is_data;
    logic is_pil;
    logic hit;
    logic room;
    logic cam_full;
    logic accept;
    logic cam_push;

    always_comb
    begin
        is_load = (samples.op == opte_pkg::OP_LOAD);
        is_data = !is_load && samples.occupied && !samples.is_pilot;
        is_pil  = !is_load && samples.occupied && samples.is_pilot;

        // A tap update still in flight for this carrier blocks any data word or load word for it.
        hit = 1'b0;
        for (int i = 0; i < opte_pkg::CAM_DEPTH; i++)
        begin
            if (cam_vld_reg[i] && (cam_car_reg[i] == samples.carrier))
            begin
                hit = 1'b1;
            end
        end

        room = ({1'b0, q_count} + (opte_pkg::QCNT_W + 1)'(s1_valid_reg))
               < (opte_pkg::QCNT_W + 1)'(opte_pkg::QUEUE_DEPTH);
        cam_full = (cam_cnt_reg == opte_pkg::CAM_CNT_W'(opte_pkg::CAM_DEPTH));

        samples.ready = room && !((is_load || is_data) && hit)
                        && !(is_load && wr.en) && !(is_pil && cam_full);
        accept   = samples.valid && samples.ready;
        cam_push = accept && is_pil;
        cam_cnt_next = cam_cnt_reg + opte_pkg::CAM_CNT_W'(cam_push)
                       - opte_pkg::CAM_CNT_W'(wr.en);

        cam_vld_next = cam_vld_reg;
        if (wr.en)
        begin
            cam_vld_next[cam_rd_reg] = 1'b0;
        end
        if (cam_push)
        begin
            cam_vld_next[cam_wr_reg] = 1'b1;
        end

        s1_item_next.kind      = is_pil  ? opte_pkg::KIND_PILOT :
                                 is_data ? opte_pkg::KIND_DATA : opte_pkg::KIND_PASS;
        s1_item_next.carrier   = samples.carrier;
        s1_item_next.frame_end = samples.frame_end;
        s1_item_next.s_re      = samples.sample_re;
        s1_item_next.s_im      = samples.sample_im;
        s1_item_next.pl_re     = samples.pilot_re;
        s1_item_next.pl_im     = samples.pilot_im;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            cam_vld_reg  <= '0;
            cam_wr_reg   <= '0;
            cam_rd_reg   <= '0;
            cam_cnt_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= accept && (samples.op == opte_pkg::OP_EQ);
            cam_vld_reg  <= cam_vld_next;
            if (wr.en)
            begin
                cam_rd_reg <= cam_rd_reg + 1'b1;
            end
            if (cam_push)
            begin
                cam_wr_reg <= cam_wr_reg + 1'b1;
            end
            cam_cnt_reg <= cam_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cam_push)
        begin
            cam_car_reg[cam_wr_reg] <= samples.carrier;
        end
        if (accept)
        begin
            s1_item_reg <= s1_item_next;
        end
    end

    // Tap memory: one write port shared by loads and pilot updates, one read port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            tap_mem[wr.carrier] <= wr.tap;
        end
        else if (accept && is_load)
        begin
            tap_mem[samples.carrier] <= {samples.sample_re, samples.sample_im};
        end
        if (accept)
        begin
            rd_reg <= tap_mem[samples.carrier];
        end
    end

    always_comb
    begin
        push                = s1_valid_reg;
        push_data.kind      = s1_item_reg.kind;
        push_data.carrier   = s1_item_reg.carrier;
        push_data.frame_end = s1_item_reg.frame_end;
        push_data.a_re      = s1_item_reg.s_re;
        push_data.a_im      = s1_item_reg.s_im;
        if (s1_item_reg.kind == opte_pkg::KIND_DATA)
        begin
            push_data.b_re = rd_reg[opte_pkg::TAP_W-1:opte_pkg::SAMPLE_W];
            push_data.b_im = rd_reg[opte_pkg::SAMPLE_W-1:0];
        end
        else
        begin
            push_data.b_re = s1_item_reg.pl_re;
            push_data.b_im = s1_item_reg.pl_im;
        end
        if (s1_item_reg.kind == opte_pkg::KIND_PASS)
        begin
            push_data.p_re = s1_item_reg.s_re;
            push_data.p_im = s1_item_reg.s_im;
        end
        else
        begin
            push_data.p_re = s1_item_reg.pl_re;
            push_data.p_im = s1_item_reg.pl_im;
        end
    end

endmodule

// File: hw/rtl/opte_back.sv
// Back of the equalizer: pipelined complex divide, rounding, saturation and output register.
module opte_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  opte_pkg::work_t    head,
    output logic               pop,
    output opte_pkg::tap_wr_t  wr,
    opte_out_if.source         results
);

    localparam int QW = opte_pkg::QUO_W;
    localparam int SW = opte_pkg::SAMPLE_W;
    localparam logic [QW-1:0] Q_CAP     = {1'b1, {(QW - 1){1'b0}}};
    localparam logic [QW-1:0] Q_NEG_LIM = QW'(2 ** (SW - 1));
    localparam logic [QW-1:0] Q_POS_LIM = QW'(2 ** (SW - 1) - 1);
    localparam logic [SW-1:0] S_MAX     = {1'b0, {(SW - 1){1'b1}}};
    localparam logic [SW-1:0] S_MIN     = {1'b1, {(SW - 1){1'b0}}};

    typedef struct packed {
        opte_pkg::kind_t            kind;
        logic [opte_pkg::CAR_W-1:0] carrier;
        logic                       frame_end;
        logic [SW-1:0]              p_re;
        logic [SW-1:0]              p_im;
    } ctl_t;

    typedef struct packed {
        logic                                 a_neg_re;
        logic                                 a_neg_im;
        logic signed [opte_pkg::MAG_W-1:0]    rr;
        logic signed [opte_pkg::MAG_W-1:0]    ii;
        logic signed [opte_pkg::MAG_W-1:0]    ir;
        logic signed [opte_pkg::MAG_W-1:0]    ri;
        logic signed [opte_pkg::MAG_W-1:0]    bb_re;
        logic signed [opte_pkg::MAG_W-1:0]    bb_im;
    } prod_t;

    typedef struct packed {
        logic                         neg_re;
        logic                         neg_im;
        logic                         den_zero;
        logic [opte_pkg::MAG_W-1:0]   mag_re;
        logic [opte_pkg::MAG_W-1:0]   mag_im;
        logic [opte_pkg::DEN_W-1:0]   den;
    } sum_t;

    typedef struct packed {
        logic [opte_pkg::REM_W-1:0] rem;
        logic [opte_pkg::LOW_W-1:0] low;
        logic [QW-1:0]              q;
    } dpart_t;

    typedef struct packed {
        logic                       neg_re;
        logic                       neg_im;
        logic                       den_zero;
        logic                       ovf_re;
        logic                       ovf_im;
        logic [opte_pkg::DEN_W-1:0] den;
        dpart_t                     re;
        dpart_t                     im;
    } div_t;

    typedef struct packed {
        logic          err;
        logic [SW-1:0] val;
    } fin_t;

    function automatic dpart_t div_step(dpart_t cur, logic [opte_pkg::DEN_W-1:0] den);
        dpart_t                     nxt;
        logic [opte_pkg::REM_W-1:0] t;
        t       = {cur.rem[opte_pkg::REM_W-2:0], cur.low[opte_pkg::LOW_W-1]};
        nxt.low = cur.low << 1;
        if (t >= {1'b0, den})
        begin
            nxt.rem = t - {1'b0, den};
            nxt.q   = {cur.q[QW-2:0], 1'b1};
        end
        else
        begin
            nxt.rem = t;
            nxt.q   = {cur.q[QW-2:0], 1'b0};
        end
        return nxt;
    endfunction

    function automatic dpart_t div_init(logic [opte_pkg::MAG_W-1:0] m);
        dpart_t d;
        d.rem = opte_pkg::REM_W'(m >> opte_pkg::LOW_W);
        d.low = m[opte_pkg::LOW_W-1:0];
        d.q   = '0;
        return d;
    endfunction

    // Round half away from zero on the magnitude, then saturate by sign.
    function automatic fin_t finish(logic neg, logic den_zero, logic ovf, logic [QW-1:0] q);
        fin_t          f;
        logic [QW-1:0] qe;
        logic [QW-1:0] rnd;
        qe    = (ovf || (q > Q_CAP)) ? Q_CAP : q;
        rnd   = (qe + QW'(1)) >> 1;
        f.err = 1'b0;
        f.val = rnd[SW-1:0];
        if (den_zero)
        begin
            f.err = 1'b1;
            f.val = neg ? S_MIN : S_MAX;
        end
        else if (neg)
        begin
            if (rnd > Q_NEG_LIM)
            begin
                f.err = 1'b1;
                f.val = S_MIN;
            end
            else
            begin
                f.val = -rnd[SW-1:0];
            end
        end
        else if (rnd > Q_POS_LIM)
        begin
            f.err = 1'b1;
            f.val = S_MAX;
        end
        return f;
    endfunction

    logic                  en;
    logic                  p_vld_reg;
    ctl_t                  p_ctl_reg;
    prod_t                 p_reg;
    prod_t                 p_next;
    logic                  s_vld_reg;
    ctl_t                  s_ctl_reg;
    sum_t                  s_reg;
    sum_t                  s_next;
    logic [QW:0]           d_vld_reg;
    ctl_t                  d_ctl_reg [QW + 1];
    div_t                  d_reg [QW + 1];
    div_t                  d0_next;
    ctl_t                  head_ctl;
    ctl_t                  last_ctl;
    fin_t                  fin_re;
    fin_t                  fin_im;

    logic                  out_valid_reg;
    logic [opte_pkg::CAR_W-1:0] out_car_reg;
    logic [SW-1:0]         out_re_reg;
    logic [SW-1:0]         out_im_reg;
    logic                  out_err_reg;
    logic                  out_fe_reg;

    logic signed [opte_pkg::MAG_W:0] num_re;
    logic signed [opte_pkg::MAG_W:0] num_im;

    assign en  = !out_valid_reg || results.ready;
    assign pop = en && head_valid;

    always_comb
    begin
        head_ctl.kind      = head.kind;
        head_ctl.carrier   = head.carrier;
        head_ctl.frame_end = head.frame_end;
        head_ctl.p_re      = head.p_re;
        head_ctl.p_im      = head.p_im;

        p_next.a_neg_re = head.a_re[SW-1];
        p_next.a_neg_im = head.a_im[SW-1];
        p_next.rr       = head.a_re * head.b_re;
        p_next.ii       = head.a_im * head.b_im;
        p_next.ir       = head.a_im * head.b_re;
        p_next.ri       = head.a_re * head.b_im;
        p_next.bb_re    = head.b_re * head.b_re;
        p_next.bb_im    = head.b_im * head.b_im;

        num_re = {p_reg.rr[opte_pkg::MAG_W-1], p_reg.rr}
                 + {p_reg.ii[opte_pkg::MAG_W-1], p_reg.ii};
        num_im = {p_reg.ir[opte_pkg::MAG_W-1], p_reg.ir}
                 - {p_reg.ri[opte_pkg::MAG_W-1], p_reg.ri};
        s_next.den      = opte_pkg::DEN_W'(p_reg.bb_re) + opte_pkg::DEN_W'(p_reg.bb_im);
        s_next.den_zero = (s_next.den == '0);
        // With a zero divisor the saturation follows the sign of the dividend itself.
        s_next.neg_re   = s_next.den_zero ? p_reg.a_neg_re : num_re[opte_pkg::MAG_W];
        s_next.neg_im   = s_next.den_zero ? p_reg.a_neg_im : num_im[opte_pkg::MAG_W];
        s_next.mag_re   = num_re[opte_pkg::MAG_W] ? opte_pkg::MAG_W'(-num_re)
                                                  : opte_pkg::MAG_W'(num_re);
        s_next.mag_im   = num_im[opte_pkg::MAG_W] ? opte_pkg::MAG_W'(-num_im)
                                                  : opte_pkg::MAG_W'(num_im);

        d0_next.neg_re   = s_reg.neg_re;
        d0_next.neg_im   = s_reg.neg_im;
        d0_next.den_zero = s_reg.den_zero;
        d0_next.den      = s_reg.den;
        d0_next.re       = div_init(s_reg.mag_re);
        d0_next.im       = div_init(s_reg.mag_im);
        // The quotient overflows its width exactly when the top dividend bits reach the divisor.
        d0_next.ovf_re   = (s_reg.mag_re >> opte_pkg::LOW_W) >= s_reg.den;
        d0_next.ovf_im   = (s_reg.mag_im >> opte_pkg::LOW_W) >= s_reg.den;

        last_ctl = d_ctl_reg[QW];
        fin_re   = finish(d_reg[QW].neg_re, d_reg[QW].den_zero, d_reg[QW].ovf_re,
                          d_reg[QW].re.q);
        fin_im   = finish(d_reg[QW].neg_im, d_reg[QW].den_zero, d_reg[QW].ovf_im,
                          d_reg[QW].im.q);

        wr.en      = en && d_vld_reg[QW] && (last_ctl.kind == opte_pkg::KIND_PILOT);
        wr.carrier = last_ctl.carrier;
        wr.tap     = {fin_re.val, fin_im.val};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg     <= 1'b0;
            s_vld_reg     <= 1'b0;
            d_vld_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_vld_reg     <= head_valid;
            s_vld_reg     <= p_vld_reg;
            d_vld_reg     <= {d_vld_reg[QW-1:0], s_vld_reg};
            out_valid_reg <= d_vld_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ctl_reg    <= head_ctl;
            p_reg        <= p_next;
            s_ctl_reg    <= p_ctl_reg;
            s_reg        <= s_next;
            d_ctl_reg[0] <= s_ctl_reg;
            d_reg[0]     <= d0_next;
            for (int i = 1; i <= QW; i++)
            begin
                d_ctl_reg[i]          <= d_ctl_reg[i-1];
                d_reg[i].neg_re       <= d_reg[i-1].neg_re;
                d_reg[i].neg_im       <= d_reg[i-1].neg_im;
                d_reg[i].den_zero     <= d_reg[i-1].den_zero;
                d_reg[i].ovf_re       <= d_reg[i-1].ovf_re;
                d_reg[i].ovf_im       <= d_reg[i-1].ovf_im;
                d_reg[i].den          <= d_reg[i-1].den;
                d_reg[i].re           <= div_step(d_reg[i-1].re, d_reg[i-1].den);
                d_reg[i].im           <= div_step(d_reg[i-1].im, d_reg[i-1].den);
            end

            out_car_reg <= last_ctl.carrier;
            out_fe_reg  <= last_ctl.frame_end;
            case (last_ctl.kind)
                opte_pkg::KIND_DATA:
                begin
                    out_re_reg  <= fin_re.val;
                    out_im_reg  <= fin_im.val;
                    out_err_reg <= fin_re.err || fin_im.err;
                end
                opte_pkg::KIND_PILOT:
                begin
                    out_re_reg  <= last_ctl.p_re;
                    out_im_reg  <= last_ctl.p_im;
                    out_err_reg <= fin_re.err || fin_im.err;
                end
                default:
                begin
                    out_re_reg  <= last_ctl.p_re;
                    out_im_reg  <= last_ctl.p_im;
                    out_err_reg <= 1'b0;
                end
            endcase
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.carrier_out   = out_car_reg;
    assign results.out_re        = out_re_reg;
    assign results.out_im        = out_im_reg;
    assign results.div_error     = out_err_reg;
    assign results.frame_end_out = out_fe_reg;

endmodule

// File: hw/rtl/ofdm_pilot_tap_equalizer.sv
// Throughput: one word per cycle while the output does not stall and no tap update holds the
// input, set by the pipelined divider of one quotient bit per stage.
// A load or data word for a carrier whose pilot tap update is still in the pipeline waits
// until that update is written to the tap memory.
// Reset clears all control state; the tap memory is not cleared, and a tap reads as
// undefined until a load word or a pilot word has written it.
module ofdm_pilot_tap_equalizer (
    input  logic        clk,
    input  logic        rst_n,
    opte_in_if.sink     samples,
    opte_out_if.source  results
);

    opte_pkg::tap_wr_t                wr;
    logic [opte_pkg::QCNT_W-1:0]      q_count;
    logic                             push;
    opte_pkg::work_t                  push_data;
    logic                             pop;
    opte_pkg::work_t                  head;
    logic                             head_valid;

    assign head_valid = (q_count != '0);

    opte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .wr        (wr),
        .q_count   (q_count),
        .push      (push),
        .push_data (push_data)
    );

    opte_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .count     (q_count)
    );

    opte_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .wr         (wr),
        .results    (results)
    );

`ifndef SYNTHESIS
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (q_count < opte_pkg::QCNT_W'(opte_pkg::QUEUE_DEPTH)))
        else $error("word pushed into a full queue");

    a_tap_write_advances: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (!results.valid || results.ready))
        else $error("tap update while the back pipeline is stalled");

    a_load_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready && (samples.op == opte_pkg::OP_LOAD)) |-> !wr.en)
        else $error("tap load accepted during a pilot tap update");
`endif

endmodule

// File: dv/opte_eq_checker.sv
// Checker for the pilot-tap equalizer: predicts each result word and compares it.
`timescale 1ns / 100ps

module opte_eq_checker (
    input  logic       clk,
    input  logic       rst_n,
    opte_in_if         samples,
    opte_out_if        results,
    output int         mismatches,
    output int         pending
);

    typedef struct {
        logic [opte_pkg::CAR_W-1:0]    carrier;
        logic [opte_pkg::SAMPLE_W-1:0] re;
        logic [opte_pkg::SAMPLE_W-1:0] im;
        logic                          err;
        logic                          fe;
    } eq_word_t;

    eq_word_t              eq_expected[$];
    logic signed [opte_pkg::SAMPLE_W-1:0] tap_re[opte_pkg::FFT_LEN];
    logic signed [opte_pkg::SAMPLE_W-1:0] tap_im[opte_pkg::FFT_LEN];

    // Rounded num * 2^14 / den, half away from zero, with the quotient capped.
    function automatic longint unsigned round_quot(longint unsigned num,
                                                   longint unsigned den);
        longint unsigned q;
        q = (num << (opte_pkg::FRAC_BITS + 1)) / den;
        if (q > (64'd1 << (opte_pkg::SAMPLE_W + 1)))
            q = 64'd1 << (opte_pkg::SAMPLE_W + 1);
        return (q + 64'd1) >> 1;
    endfunction

    function automatic longint sat_part(bit neg, longint unsigned m,
                                        longint unsigned den, inout bit err);
        longint unsigned q;
        if (den == 0) begin
            err = 1'b1;
            return neg ? -64'sd32768 : 64'sd32767;
        end
        q = round_quot(m, den);
        if (neg) begin
            if (q > 32768) begin
                err = 1'b1;
                return -64'sd32768;
            end
            return -longint'(q);
        end
        if (q > 32767) begin
            err = 1'b1;
            return 64'sd32767;
        end
        return longint'(q);
    endfunction

    function automatic bit complex_div(longint ar, longint ai, longint br, longint bi,
                                       output longint qr, output longint qi);
        bit err;
        longint unsigned den;
        longint sr, si;
        err = 1'b0;
        den = longint'(br * br + bi * bi);
        if (den == 0) begin
            sr = (ar < 0) ? -64'sd1 : 64'sd0;
            si = (ai < 0) ? -64'sd1 : 64'sd0;
        end else begin
            sr = ar * br + ai * bi;
            si = ai * br - ar * bi;
        end
        qr = sat_part(sr < 0, (sr < 0) ? -sr : sr, den, err);
        qi = sat_part(si < 0, (si < 0) ? -si : si, den, err);
        return err;
    endfunction

    assign pending = eq_expected.size();

    always @(posedge clk or negedge rst_n) begin
        eq_word_t got, want;
        longint   qr, qi;
        bit       bad;
        if (!rst_n) begin
            mismatches <= 0;
            eq_expected.delete();
        end else begin
            if (results.valid && results.ready) begin
                got.carrier = results.carrier_out;
                got.re      = results.out_re;
                got.im      = results.out_im;
                got.err     = results.div_error;
                got.fe      = results.frame_end_out;
                if (eq_expected.size() == 0) begin
                    $error("result word for carrier %0d with none expected", got.carrier);
                    mismatches <= mismatches + 1;
                end else begin
                    want = eq_expected.pop_front();
                    bad  = 1'b0;
                    if (got.carrier !== want.carrier) begin
                        $error("carrier_out: expected %0d, got %0d", want.carrier, got.carrier);
                        bad = 1'b1;
                    end
                    if (got.re !== want.re) begin
                        $error("out_re: expected %0d, got %0d",
                               $signed(want.re), $signed(got.re));
                        bad = 1'b1;
                    end
                    if (got.im !== want.im) begin
                        $error("out_im: expected %0d, got %0d",
                               $signed(want.im), $signed(got.im));
                        bad = 1'b1;
                    end
                    if (got.err !== want.err) begin
                        $error("div_error: expected %0d, got %0d", want.err, got.err);
                        bad = 1'b1;
                    end
                    if (got.fe !== want.fe) begin
                        $error("frame_end_out: expected %0d, got %0d", want.fe, got.fe);
                        bad = 1'b1;
                    end
                    if (bad)
                        mismatches <= mismatches + 1;
                end
            end
            if (samples.valid && samples.ready) begin
                if (samples.op == opte_pkg::OP_LOAD) begin
                    tap_re[samples.carrier] = samples.sample_re;
                    tap_im[samples.carrier] = samples.sample_im;
                end else begin
                    want.carrier = samples.carrier;
                    want.re      = samples.sample_re;
                    want.im      = samples.sample_im;
                    want.err     = 1'b0;
                    want.fe      = samples.frame_end;
                    if (samples.occupied && samples.is_pilot) begin
                        want.err = complex_div(samples.sample_re, samples.sample_im,
                                               samples.pilot_re, samples.pilot_im, qr, qi);
                        tap_re[samples.carrier] = qr[opte_pkg::SAMPLE_W-1:0];
                        tap_im[samples.carrier] = qi[opte_pkg::SAMPLE_W-1:0];
                        want.re = samples.pilot_re;
                        want.im = samples.pilot_im;
                    end else if (samples.occupied) begin
                        want.err = complex_div(samples.sample_re, samples.sample_im,
                                               tap_re[samples.carrier],
                                               tap_im[samples.carrier], qr, qi);
                        want.re = qr[opte_pkg::SAMPLE_W-1:0];
                        want.im = qi[opte_pkg::SAMPLE_W-1:0];
                    end
                    eq_expected.push_back(want);
                end
            end
        end
    end

endmodule

// File: dv/tb.sv
// Testbench top of the pilot-tap equalizer: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module tb;

    typedef struct {
        logic                                 op;
        logic [opte_pkg::CAR_W-1:0]           carrier;
        logic signed [opte_pkg::SAMPLE_W-1:0] s_re;
        logic signed [opte_pkg::SAMPLE_W-1:0] s_im;
        logic                                 occ;
        logic                                 pil;
        logic signed [opte_pkg::SAMPLE_W-1:0] p_re;
        logic signed [opte_pkg::SAMPLE_W-1:0] p_im;
        logic                                 fe;
    } sc_word_t;

    localparam int RUN_LIMIT = 200000;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   cycles;
    int   burst_left;
    bit   tap_known[opte_pkg::FFT_LEN];

    opte_in_if  samples ();
    opte_out_if results ();

    ofdm_pilot_tap_equalizer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .results (results)
    );

    opte_eq_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .results    (results),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > RUN_LIMIT) begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // Receiver: stall pattern steps through four modes, plus one long hold-off.
    initial begin
        int rx_cycle;
        rx_cycle = 0;
        results.ready = 1'b0;
        forever begin
            @(negedge clk);
            rx_cycle++;
            if (rx_cycle >= 600 && rx_cycle < 900)
                results.ready = 1'b0;
            else
                case ((rx_cycle / 300) % 4)
                    0: results.ready = 1'b1;
                    1: results.ready = 1'($urandom_range(0, 1));
                    2: results.ready = ($urandom_range(0, 7) != 0);
                    default: results.ready = ($urandom_range(0, 3) == 0);
                endcase
        end
    end

    function automatic logic signed [opte_pkg::SAMPLE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sd0;
            3: return 16'sd16384;
            4, 5: return 16'($urandom_range(0, 65535));
            default: return $signed(16'($urandom_range(0, 24000))) - 16'sd12000;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send(input sc_word_t w);
        if (burst_left == 0) begin
            samples.valid = 1'b0;
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        samples.valid     = 1'b1;
        samples.op        = w.op;
        samples.carrier   = w.carrier;
        samples.sample_re = w.s_re;
        samples.sample_im = w.s_im;
        samples.occupied  = w.occ;
        samples.is_pilot  = w.pil;
        samples.pilot_re  = w.p_re;
        samples.pilot_im  = w.p_im;
        samples.frame_end = w.fe;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        @(negedge clk);
        if (w.op == opte_pkg::OP_LOAD || (w.occ && w.pil))
            tap_known[w.carrier] = 1'b1;
    endtask

    function automatic sc_word_t make_word(logic op, int car, int sr, int si, logic occ,
                                           logic pil, int pr, int pi, logic fe);
        sc_word_t w;
        w.op = op;
        w.carrier = opte_pkg::CAR_W'(car);
        w.s_re = opte_pkg::SAMPLE_W'(sr);
        w.s_im = opte_pkg::SAMPLE_W'(si);
        w.occ = occ;
        w.pil = pil;
        w.p_re = opte_pkg::SAMPLE_W'(pr);
        w.p_im = opte_pkg::SAMPLE_W'(pi);
        w.fe = fe;
        return w;
    endfunction

    function automatic sc_word_t random_word();
        sc_word_t w;
        int       roll;
        w.carrier = ($urandom_range(0, 9) < 7)
                    ? opte_pkg::CAR_W'($urandom_range(0, 15))
                    : opte_pkg::CAR_W'($urandom_range(0, opte_pkg::FFT_LEN - 1));
        w.s_re = pick_value();
        w.s_im = pick_value();
        w.p_re = pick_value();
        w.p_im = pick_value();
        w.fe   = ($urandom_range(0, 7) == 0);
        w.op   = opte_pkg::OP_EQ;
        w.occ  = 1'b1;
        w.pil  = 1'b0;
        roll   = $urandom_range(0, 99);
        if (roll < 15)
            w.op = opte_pkg::OP_LOAD;
        else if (roll < 40)
            w.pil = 1'b1;
        else if (roll < 50) begin
            w.occ = 1'b0;
            w.pil = 1'($urandom_range(0, 1));
        end
        // Data words only go to carriers whose tap has been written.
        if (w.op == opte_pkg::OP_EQ && w.occ && !w.pil && !tap_known[w.carrier])
            w.op = opte_pkg::OP_LOAD;
        if (w.op == opte_pkg::OP_LOAD) begin
            w.occ = 1'($urandom_range(0, 1));
            w.pil = 1'($urandom_range(0, 1));
        end
        return w;
    endfunction

    initial begin
        rst_n = 1'b0;
        burst_left = 0;
        samples.valid = 1'b0;
        samples.op = opte_pkg::OP_LOAD;
        samples.carrier = '0;
        samples.sample_re = '0;
        samples.sample_im = '0;
        samples.occupied = 1'b0;
        samples.is_pilot = 1'b0;
        samples.pilot_re = '0;
        samples.pilot_im = '0;
        samples.frame_end = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed words: identity and zero taps, saturation, pilots, pass-through.
        send(make_word(opte_pkg::OP_LOAD, 0, 16384, 0, 1, 0, 0, 0, 0));
        send(make_word(opte_pkg::OP_LOAD, 1023, 0, 0, 0, 1, 0, 0, 0));
        send(make_word(opte_pkg::OP_LOAD, 5, 1, -1, 1, 1, 0, 0, 1));
        send(make_word(opte_pkg::OP_EQ, 0, 32767, -32768, 1, 0, 0, 0, 0));
        send(make_word(opte_pkg::OP_EQ, 1023, 1000, -1000, 1, 0, 0, 0, 0));
        send(make_word(opte_pkg::OP_EQ, 1023, -5, 0, 1, 0, 0, 0, 1));
        send(make_word(opte_pkg::OP_EQ, 5, 32767, 32767, 1, 0, 0, 0, 0));
        send(make_word(opte_pkg::OP_EQ, 5, 0, 0, 1, 0, 0, 0, 0));
        send(make_word(opte_pkg::OP_EQ, 700, -32768, 32767, 0, 0, 7, 7, 1));
        send(make_word(opte_pkg::OP_EQ, 701, 123, 456, 0, 1, -32768, 32767, 0));
        send(make_word(opte_pkg::OP_EQ, 9, 8192, -8192, 1, 1, 16384, 0, 0));
        send(make_word(opte_pkg::OP_EQ, 9, 12000, 3000, 1, 0, 0, 0, 0));
        send(make_word(opte_pkg::OP_EQ, 10, 500, -700, 1, 1, 0, 0, 0));
        send(make_word(opte_pkg::OP_EQ, 10, 500, -700, 1, 0, 0, 0, 1));
        send(make_word(opte_pkg::OP_EQ, 11, 32767, -32768, 1, 1, 1, 0, 0));
        send(make_word(opte_pkg::OP_EQ, 11, 1, 1, 1, 0, 0, 0, 0));
        send(make_word(opte_pkg::OP_EQ, 12, -32768, -32768, 1, 1, -32768, -32768, 0));
        send(make_word(opte_pkg::OP_EQ, 12, 32767, 32767, 1, 0, 0, 0, 0));
        send(make_word(opte_pkg::OP_EQ, 13, 16384, 16384, 1, 1, 16384, -16384, 0));
        send(make_word(opte_pkg::OP_LOAD, 13, 0, 16384, 1, 0, 0, 0, 0));
        send(make_word(opte_pkg::OP_EQ, 13, 16384, 0, 1, 0, 0, 0, 1));

        repeat (1400)
            send(random_word());
        samples.valid = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
